@@ hdl/assert_macros.svh @@
// Assertion macros for the RGBE codec; rgbe_quant is the module that includes them.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/rgbe_pkg.sv @@
// Types and helper functions for the RGBE pixel codec.
// No dependencies.
`timescale 1ns / 1ps
package rgbe_pkg;
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic [31:0] packed_word;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] red_result;
        logic [31:0] green_result;
        logic [31:0] blue_result;
        logic [31:0] packed_result;
    } pix_out_t;

    // Position of the highest set bit of a 23-bit value (0 for zero).
    function automatic logic [4:0] top_bit23(input logic [22:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 23; i++)
            if (v[i]) p = 5'(i);
        return p;
    endfunction

    // Position of the highest set bit of a 9-bit value.
    function automatic logic [3:0] top_bit9(input logic [8:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 9; i++)
            if (v[i]) p = 4'(i);
        return p;
    endfunction

    // Decode one color byte with exponent byte e to IEEE single bits.
    function automatic logic [31:0] decode_channel(input logic [7:0] c, input logic [7:0] e);
        logic [8:0]  n;
        logic [3:0]  p;
        logic signed [10:0] be;
        logic [31:0] r;
        n  = {c, 1'b1};
        p  = top_bit9(n);
        be = 11'($signed({7'd0, p})) + 11'($signed({3'd0, e})) - 11'sd10;
        if (be >= 11'sd1)
            r = {1'b0, be[7:0], 23'((32'(n) << (5'd23 - 5'(p))) & 32'h7FFFFF)};
        else
            r = 32'(n) << (6'(e) + 6'd12);
        return r;
    endfunction

    // Quantize a nonnegative finite float to a byte with shared exponent ex.
    function automatic logic [7:0] quantize(input logic [31:0] bits, input logic [7:0] ex);
        logic [7:0]  fe;
        logic [23:0] m;
        logic signed [10:0] s;
        logic signed [10:0] t;
        logic [5:0]  r;
        logic [63:0] v;
        logic [7:0]  q;
        fe = bits[30:23];
        if (fe != 8'd0)
        begin
            m = {1'b1, bits[22:0]};
            s = 11'($signed({3'd0, fe})) - 11'sd150;
        end
        else
        begin
            m = {1'b0, bits[22:0]};
            s = -11'sd149;
        end
        t = s + 11'sd136 - 11'($signed({3'd0, ex}));
        q = 8'd0;
        if (m == 24'd0)
            q = 8'd0;
        else if (t >= 11'sd0)
        begin
            if (t >= 11'sd8)
                q = 8'd255;
            else
            begin
                v = 64'(m) << t[2:0];
                q = (v > 64'd255) ? 8'd255 : v[7:0];
            end
        end
        else if (t < -11'sd40)
            q = 8'd0;
        else
        begin
            r = 6'(-t);
            v = (64'(m) + (64'd1 << (r - 6'd1))) >> r;
            q = (v > 64'd255) ? 8'd255 : v[7:0];
        end
        return q;
    endfunction
endpackage

@@ hdl/rgbe_prep.sv @@
// Stage 1 of the codec: classifies components and finds the largest one.
// Depends on rgbe_pkg.
`timescale 1ns / 1ps
module rgbe_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  rgbe_pkg::pix_in_t in_data,
    output logic             vld_reg,
    output logic             op_reg,
    output logic [31:0]      comp_reg [3],
    output logic [2:0]       sat_reg,
    output logic [31:0]      max_reg,
    output logic [31:0]      word_reg
);
    import rgbe_pkg::*;

    logic [31:0] comp_next [3];
    logic [2:0]  sat_next;
    logic [31:0] bits [3];
    logic [31:0] mx;

    // Screen out NaN, infinity and negative values, then take the maximum.
    // A NaN of either sign and positive infinity saturate; negative infinity
    // counts as zero like any other negative value.
    always_comb
    begin
        bits[0] = in_data.red_bits;
        bits[1] = in_data.green_bits;
        bits[2] = in_data.blue_bits;
        mx = 32'd0;
        for (int i = 0; i < 3; i++)
        begin
            sat_next[i]  = (bits[i][30:0] > 31'h7F800000) ||
                           ((bits[i][30:0] == 31'h7F800000) && !bits[i][31]);
            comp_next[i] = (sat_next[i] || bits[i][31]) ? 32'd0 : bits[i];
            if (comp_next[i] > mx) mx = comp_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= in_data.op;
            comp_reg <= comp_next;
            sat_reg  <= sat_next;
            max_reg  <= mx;
            word_reg <= in_data.packed_word;
        end
    end
endmodule

@@ hdl/rgbe_expo.sv @@
// Stage 2 of the codec: shared exponent for encoding, channel decode.
// Depends on rgbe_pkg.
`timescale 1ns / 1ps
module rgbe_expo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic        op,
    input  logic [31:0] comp [3],
    input  logic [2:0]  sat,
    input  logic [31:0] mx,
    input  logic [31:0] word,
    output logic        vld_reg,
    output logic        op_reg,
    output logic [31:0] comp_reg [3],
    output logic [2:0]  sat_reg,
    output logic [7:0]  ex_reg,
    output logic [31:0] dec_reg [3]
);
    import rgbe_pkg::*;

    logic [7:0]  ex_next;
    logic signed [9:0] k;
    logic signed [9:0] ext;
    logic [31:0] dec_next [3];

    // Exponent from the largest component, clamped to a byte; 255 when any component saturates, 128 when all are zero.
    always_comb
    begin
        k = 10'sd0;
        if (mx[30:23] != 8'd0)
            k = 10'($signed({2'd0, mx[30:23]})) - 10'sd126;
        else
            k = 10'($signed({5'd0, top_bit23(mx[22:0])})) - 10'sd148;
        ext = k + 10'sd128;
        if (sat != 3'd0)
            ex_next = 8'd255;
        else if (mx == 32'd0)
            ex_next = 8'd128;
        else if (ext < 10'sd0)
            ex_next = 8'd0;
        else if (ext > 10'sd255)
            ex_next = 8'd255;
        else
            ex_next = ext[7:0];
    end

    // Decode path; an all-zero word gives zeros.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dec_next[i] = (word == 32'd0) ? 32'd0
                        : decode_channel(word[8*i +: 8], word[31:24]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op;
            comp_reg <= comp;
            sat_reg  <= sat;
            ex_reg   <= ex_next;
            dec_reg  <= dec_next;
        end
    end
endmodule

@@ hdl/rgbe_quant.sv @@
// Stage 3 of the codec: quantizes components and forms the result.
// Depends on rgbe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
module rgbe_quant (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic              op,
    input  logic [31:0]       comp [3],
    input  logic [2:0]        sat,
    input  logic [7:0]        ex,
    input  logic [31:0]       dec [3],
    output logic              vld_reg,
    output rgbe_pkg::pix_out_t data_reg
);
    import rgbe_pkg::*;
    `include "assert_macros.svh"

    pix_out_t data_next;
    logic [7:0] q [3];

    // Build the result word for either direction.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            q[i] = sat[i] ? 8'd255 : quantize(comp[i], ex);
        if (op == OP_DECODE)
        begin
            data_next.red_result    = dec[0];
            data_next.green_result  = dec[1];
            data_next.blue_result   = dec[2];
            data_next.packed_result = 32'd0;
        end
        else
        begin
            data_next.red_result    = 32'd0;
            data_next.green_result  = 32'd0;
            data_next.blue_result   = 32'd0;
            data_next.packed_result = {ex, q[2], q[1], q[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    `ASSERT_IMPL(a_sat_exp, clk, rst_n, in_vld && en && op == OP_ENCODE && sat != 3'd0,
        ex == 8'd255)
    `ASSERT_NEXT(a_hold, clk, rst_n, vld_reg && !en, vld_reg && $stable(data_reg))
    `ASSERT_NEXT(a_enc_zero, clk, rst_n, en && in_vld && op == OP_ENCODE,
        data_reg.red_result == 32'd0)
endmodule

@@ hdl/rgbe_pixel_codec.sv @@
// Top level of the RGBE pixel codec: three-stage pipeline.
// Depends on rgbe_pkg, rgbe_prep, rgbe_expo and rgbe_quant.
//   channel | signals              | direction
//   in      | in_valid/in_stall    | pixel or RGBE word in
//   out     | out_valid/out_stall  | converted pixel out
// One item per clock while the output is not stalled; each item passes the three stage registers.
// Reset clears the stage valid bits only.
// A stall on the output holds the last stage and each full stage behind a held one,
// so in_stall follows out_stall when every stage is full; empty stages still fill.
`timescale 1ns / 1ps
module rgbe_pixel_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rgbe_pkg::pix_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rgbe_pkg::pix_out_t out_data
);
    import rgbe_pkg::*;

    logic        v1, v2, v3;
    logic        op1, op2;
    logic [31:0] comp1 [3];
    logic [31:0] comp2 [3];
    logic [2:0]  sat1, sat2;
    logic [31:0] max1, word1;
    logic [7:0]  ex2;
    logic [31:0] dec2 [3];
    logic        en3, en2, en1;

    // Each stage advances when it is empty or the stage after it can take its item.
    assign en3 = !(v3 && out_stall);
    assign en2 = en3 || !v2;
    assign en1 = en2 || !v1;
    assign in_stall = !en1;
    assign out_valid = v3;

    rgbe_prep u_prep (
        .clk(clk), .rst_n(rst_n), .en(en1), .in_vld(in_valid), .in_data(in_data),
        .vld_reg(v1), .op_reg(op1), .comp_reg(comp1), .sat_reg(sat1),
        .max_reg(max1), .word_reg(word1)
    );

    rgbe_expo u_expo (
        .clk(clk), .rst_n(rst_n), .en(en2), .in_vld(v1), .op(op1), .comp(comp1),
        .sat(sat1), .mx(max1), .word(word1), .vld_reg(v2), .op_reg(op2),
        .comp_reg(comp2), .sat_reg(sat2), .ex_reg(ex2), .dec_reg(dec2)
    );

    rgbe_quant u_quant (
        .clk(clk), .rst_n(rst_n), .en(en3), .in_vld(v2), .op(op2), .comp(comp2),
        .sat(sat2), .ex(ex2), .dec(dec2), .vld_reg(v3), .data_reg(out_data)
    );
endmodule

@@ tb/sv/tb_rgbe_pixel_codec.sv @@
// Self-checking testbench for the RGBE pixel codec: directed rows, then random pixels.
// Depends on rgbe_pkg and the rgbe_pixel_codec top level.
`timescale 1ns / 1ps
module tb_rgbe_pixel_codec;
    import rgbe_pkg::*;

    localparam int RANDOM_ITEMS = 630;
    localparam int DRAIN_CYCLES = 8;

    // One directed row: stimulus, and a typed-in expectation where known.
    typedef struct {
        pix_in_t  stim;
        logic     has_fixed;
        pix_out_t fixed;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pix_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    pix_out_t out_data;

    pix_out_t  pending_pixels[$];
    stim_row_t rows[$];
    int        mismatch_count;
    bit        stim_done;

    rgbe_pixel_codec dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Highest set bit position of a value.
    function automatic int msb_pos(input logic [31:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 32; i++)
            if (v[i]) p = i;
        return p;
    endfunction

    // Expand one color byte with exponent byte e to single-precision bits.
    function automatic logic [31:0] expand_byte(input logic [7:0] c, input logic [7:0] e);
        logic [31:0] n;
        int p;
        int be;
        n = {23'd0, c, 1'b1};
        p = msb_pos(n);
        be = p + int'(e) - 10;
        if (be >= 1)
            return {1'b0, 8'(be), 23'((n << (23 - p)) & 32'h7FFFFF)};
        return n << (int'(e) + 12);
    endfunction

    // Scale a nonnegative finite float to a byte with shared exponent ex.
    function automatic logic [7:0] scale_byte(input logic [31:0] bits, input int ex);
        logic [63:0] m;
        logic [63:0] v;
        int s;
        int t;
        if (bits[30:23] != 8'd0)
        begin
            m = {40'd0, 1'b1, bits[22:0]};
            s = int'(bits[30:23]) - 150;
        end
        else
        begin
            m = {41'd0, bits[22:0]};
            s = -149;
        end
        if (m == 64'd0)
            return 8'd0;
        t = s + 136 - ex;
        if (t >= 8)
            return 8'd255;
        if (t >= 0)
            v = m << t;
        else if (-t > 40)
            return 8'd0;
        else
            v = (m + (64'd1 << (-t - 1))) >> (-t);
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    // Expected converted pixel for one input transfer.
    function automatic pix_out_t convert_pixel(input pix_in_t px);
        pix_out_t    o;
        logic [31:0] comp[3];
        logic [31:0] raw[3];
        bit          sat[3];
        bit          special;
        logic [31:0] mx;
        int          ex;
        int          k;
        o = '0;
        if (px.op == OP_DECODE)
        begin
            if (px.packed_word != 32'd0)
            begin
                o.red_result   = expand_byte(px.packed_word[7:0], px.packed_word[31:24]);
                o.green_result = expand_byte(px.packed_word[15:8], px.packed_word[31:24]);
                o.blue_result  = expand_byte(px.packed_word[23:16], px.packed_word[31:24]);
            end
            return o;
        end
        raw[0] = px.red_bits;
        raw[1] = px.green_bits;
        raw[2] = px.blue_bits;
        special = 1'b0;
        mx = 32'd0;
        for (int i = 0; i < 3; i++)
        begin
            sat[i] = 1'b0;
            comp[i] = 32'd0;
            // NaN of either sign and +infinity saturate; other negatives count as zero.
            if (raw[i][30:0] > 31'h7F800000)
                sat[i] = 1'b1;
            else if (raw[i][31])
                comp[i] = 32'd0;
            else if (raw[i][30:0] == 31'h7F800000)
                sat[i] = 1'b1;
            else
                comp[i] = raw[i];
            if (sat[i]) special = 1'b1;
            if (comp[i] > mx) mx = comp[i];
        end
        if (special)
            ex = 255;
        else if (mx == 32'd0)
            ex = 128;
        else
        begin
            if (mx[30:23] != 8'd0)
                k = int'(mx[30:23]) - 126;
            else
                k = msb_pos({9'd0, mx[22:0]}) - 148;
            ex = k + 128;
            if (ex < 0) ex = 0;
            if (ex > 255) ex = 255;
        end
        o.packed_result[31:24] = 8'(ex);
        for (int i = 0; i < 3; i++)
            o.packed_result[8*i +: 8] = sat[i] ? 8'd255 : scale_byte(comp[i], ex);
        return o;
    endfunction

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom())};
            2: return {1'b0, 8'd0, 23'($urandom())};
            3: return {1'b0, 8'($urandom_range(0, 20)), 23'($urandom())};
            4: return {1'b0, 8'($urandom_range(230, 254)), 23'($urandom())};
            default: return {1'b0, 8'($urandom_range(118, 134)), 23'($urandom())};
        endcase
    endfunction

    function automatic pix_in_t rand_pixel();
        pix_in_t px;
        px.op = 1'($urandom_range(0, 1));
        px.red_bits = rand_float();
        px.green_bits = rand_float();
        px.blue_bits = rand_float();
        px.packed_word = $urandom();
        if ($urandom_range(0, 9) == 0)
            px.packed_word[23:0] = '0;
        if ($urandom_range(0, 19) == 0)
            px.packed_word = '0;
        return px;
    endfunction

    function automatic void add_row(input logic op, input logic [31:0] r, input logic [31:0] g,
                                    input logic [31:0] b, input logic [31:0] w,
                                    input logic has_fixed, input pix_out_t fixed);
        stim_row_t row;
        row.stim = '{op, r, g, b, w};
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        rows.push_back(row);
    endfunction

    // Present one pixel, hold it until accepted, then sometimes drop valid for a random gap.
    task automatic send_pixel(input pix_in_t px, input pix_out_t expected);
        int gap;
        in_data <= px;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pixels.push_back(expected);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver: draw a stall length per result and check each transfer.
    initial
    begin
        int hold;
        pix_out_t exp_px;
        out_stall = 1'b1;
        mismatch_count = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    exp_px = pending_pixels.pop_front();
                    if (out_data !== exp_px)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                                     exp_px.red_result, exp_px.green_result,
                                     exp_px.blue_result, exp_px.packed_result,
                                     out_data.red_result, out_data.green_result,
                                     out_data.blue_result, out_data.packed_result);
                    end
                end
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 2) == 0) hold = 0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Sender: directed table, then random pixels, then drain and report.
    initial
    begin
        pix_out_t fx;
        pix_out_t none;
        stim_row_t row;
        int waited;
        none = '0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Decode extremes: zero word, smallest and largest exponents, full bytes.
        add_row(OP_DECODE, 0, 0, 0, 32'h0000_0000, 1'b1, none);
        fx = '0;
        fx.red_result = 32'h3F00_0000;
        fx.green_result = 32'h3F00_0000;
        fx.blue_result = 32'h3F00_0000;
        add_row(OP_DECODE, 0, 0, 0, 32'h8800_0000, 1'b1, fx);
        add_row(OP_DECODE, 0, 0, 0, 32'h00FF_FFFF, 1'b0, none);
        add_row(OP_DECODE, 0, 0, 0, 32'h0100_0000, 1'b0, none);
        add_row(OP_DECODE, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, none);
        add_row(OP_DECODE, 0, 0, 0, 32'hFF00_0000, 1'b0, none);
        add_row(OP_DECODE, 0, 0, 0, 32'h0A80_01FF, 1'b0, none);
        // Encode: all zero gives exponent byte 128.
        fx = '0;
        fx.packed_result = 32'h8000_0000;
        add_row(OP_ENCODE, 0, 0, 0, 0, 1'b1, fx);
        // Negatives, including negative zero and negative infinity, count as zero.
        add_row(OP_ENCODE, 32'h8000_0000, 32'hFF80_0000, 32'hBF80_0000, 0, 1'b1, fx);
        // Infinity and NaN saturate the exponent.
        fx.packed_result = 32'hFFFF_FFFF;
        add_row(OP_ENCODE, 32'h7F80_0000, 32'h7FC0_0000, 32'hFFC0_0001, 0, 1'b1, fx);
        add_row(OP_ENCODE, 32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000, 0, 1'b0, none);
        add_row(OP_ENCODE, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000, 0, 1'b0, none);
        // Tiny maximum clamps the exponent byte to zero.
        add_row(OP_ENCODE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 0, 1'b0, none);
        add_row(OP_ENCODE, 32'h007F_FFFF, 32'h0040_0000, 32'h0000_0003, 0, 1'b0, none);
        add_row(OP_ENCODE, 32'h3F80_0000, 32'h3F00_0000, 32'h3E80_0000, 0, 1'b0, none);
        add_row(OP_ENCODE, 32'h3F7F_FFFF, 32'h3B80_0000, 32'h3B7F_FFFF, 0, 1'b0, none);
        add_row(OP_ENCODE, 32'h0080_0000, 32'h0100_0000, 32'h00FF_FFFF, 0, 1'b0, none);
        add_row(OP_ENCODE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                1'b0, none);

        @(posedge clk);
        foreach (rows[i])
        begin
            row = rows[i];
            send_pixel(row.stim, row.has_fixed ? row.fixed : convert_pixel(row.stim));
        end

        // Hold off the sender until the pipeline has drained once.
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pix_in_t px;
            px = rand_pixel();
            send_pixel(px, convert_pixel(px));
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_pixels.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("rgbe_pixel_codec regression: pass");
        else
            $display("rgbe_pixel_codec regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("rgbe_pixel_codec regression: fail");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/rgbe_pkg.sv
hdl/rgbe_prep.sv
hdl/rgbe_expo.sv
hdl/rgbe_quant.sv
hdl/rgbe_pixel_codec.sv
tb/sv/tb_rgbe_pixel_codec.sv
